FILE: hdl/terminal_escape_key_decoder_assert.svh
// Assertion macros for the terminal escape key decoder.
// Expanded inside a module that has clk and an active-low rst_n in scope.
`ifndef TERMINAL_ESCAPE_KEY_DECODER_ASSERT_SVH
`define TERMINAL_ESCAPE_KEY_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TEKD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TEKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tekd_pkg.sv
// Shared types, character codes and key tables of the terminal escape key decoder.
// Used by every module under hdl; depends on nothing.
package tekd_pkg;

  localparam logic [7:0] CHAR_ESC   = 8'h1B;
  localparam logic [7:0] CHAR_CSI   = 8'h5B;  // '['
  localparam logic [7:0] CHAR_SS3   = 8'h4F;  // 'O'
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_B     = 8'h42;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_F     = 8'h46;
  localparam logic [7:0] CHAR_H     = 8'h48;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ESC   = 2'd1,
    PH_FIRST = 2'd2,
    PH_DIGIT = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    KEY_PLAIN  = 4'd0,
    KEY_UP     = 4'd1,
    KEY_DOWN   = 4'd2,
    KEY_RIGHT  = 4'd3,
    KEY_LEFT   = 4'd4,
    KEY_HOME   = 4'd5,
    KEY_END    = 4'd6,
    KEY_DEL    = 4'd7,
    KEY_PGUP   = 4'd8,
    KEY_PGDN   = 4'd9,
    KEY_ESCAPE = 4'd10
  } key_kind_t;

  typedef struct packed {
    logic       op;       // 1 = timeout, no byte
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic      vld;
    key_kind_t key_kind;
    logic [7:0] key_byte;
  } result_t;

  function automatic key_kind_t csi_letter(input logic [7:0] c);
    key_kind_t k;
    unique case (c)
      CHAR_A:  k = KEY_UP;
      CHAR_B:  k = KEY_DOWN;
      CHAR_C:  k = KEY_RIGHT;
      CHAR_D:  k = KEY_LEFT;
      CHAR_H:  k = KEY_HOME;
      CHAR_F:  k = KEY_END;
      default: k = KEY_ESCAPE;
    endcase
    return k;
  endfunction

  function automatic key_kind_t tilde_digit(input logic [3:0] d);
    key_kind_t k;
    unique case (d)
      4'd1, 4'd7: k = KEY_HOME;
      4'd4, 4'd8: k = KEY_END;
      4'd3:       k = KEY_DEL;
      4'd5:       k = KEY_PGUP;
      4'd6:       k = KEY_PGDN;
      default:    k = KEY_ESCAPE;
    endcase
    return k;
  endfunction

endpackage

FILE: hdl/tekd_in_reg.sv
// Input register of the terminal escape key decoder.
// Holds one accepted transaction until the decoder consumes it; uses tekd_pkg.
module tekd_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tekd_pkg::item_t in_item,
  input  logic           fire,
  output logic           item_vld,
  output tekd_pkg::item_t item
);
  import tekd_pkg::*;

  logic  vld_r, vld_nxt;
  item_t item_r;

  // A held item that is consumed this cycle frees the register for the next one.
  assign in_ready = !vld_r || fire;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (fire) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

FILE: hdl/tekd_decode.sv
// Escape sequence state machine of the terminal escape key decoder.
// Advances on each consumed item and produces at most one key; uses tekd_pkg.
module tekd_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  tekd_pkg::item_t  item,
  output tekd_pkg::result_t res
);
  import tekd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] first_r, first_nxt;
  logic [3:0] digit_r, digit_nxt;
  logic       is_digit;

  assign is_digit = (item.rx_byte >= CHAR_ZERO) && (item.rx_byte <= CHAR_NINE);

  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    digit_nxt = digit_r;
    if (fire) begin
      if (item.op) begin
        phase_nxt = PH_IDLE;
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            phase_nxt = (item.rx_byte == CHAR_ESC) ? PH_ESC : PH_IDLE;
          end
          PH_ESC: begin
            first_nxt = item.rx_byte;
            phase_nxt = PH_FIRST;
          end
          PH_FIRST: begin
            if (first_r == CHAR_CSI && is_digit) begin
              // The low nibble of an ASCII digit is its value.
              digit_nxt = item.rx_byte[3:0];
              phase_nxt = PH_DIGIT;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_DIGIT: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    res = '{vld: 1'b0, key_kind: KEY_PLAIN, key_byte: 8'h00};
    if (fire) begin
      if (item.op) begin
        if (phase_r != PH_IDLE) begin
          res.vld      = 1'b1;
          res.key_kind = KEY_ESCAPE;
        end
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            if (item.rx_byte != CHAR_ESC) begin
              res.vld      = 1'b1;
              res.key_kind = KEY_PLAIN;
              res.key_byte = item.rx_byte;
            end
          end
          PH_ESC: begin
            res.vld = 1'b0;
          end
          PH_FIRST: begin
            priority if (first_r == CHAR_CSI) begin
              res.vld      = !is_digit;
              res.key_kind = csi_letter(item.rx_byte);
            end else if (first_r == CHAR_SS3 && item.rx_byte == CHAR_H) begin
              res.vld      = 1'b1;
              res.key_kind = KEY_HOME;
            end else if (first_r == CHAR_SS3 && item.rx_byte == CHAR_F) begin
              res.vld      = 1'b1;
              res.key_kind = KEY_END;
            end else begin
              res.vld      = 1'b1;
              res.key_kind = KEY_ESCAPE;
            end
          end
          PH_DIGIT: begin
            res.vld      = 1'b1;
            res.key_kind = (item.rx_byte == CHAR_TILDE) ? tilde_digit(digit_r) : KEY_ESCAPE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      first_r <= 8'h00;
      digit_r <= 4'h0;
    end else begin
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      digit_r <= digit_nxt;
    end
  end

endmodule

FILE: hdl/tekd_out_reg.sv
// Result register of the terminal escape key decoder.
// Holds one decoded key until the downstream side takes it; uses tekd_pkg.
module tekd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  tekd_pkg::result_t res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_kind,
  output logic [7:0]        out_byte
);
  import tekd_pkg::*;

  logic      vld_r, vld_nxt;
  key_kind_t kind_r;
  logic [7:0] byte_r;

  assign out_free = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (res.vld) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      kind_r <= res.key_kind;
      byte_r <= res.key_byte;
    end
  end

  assign out_valid = vld_r;
  assign out_kind  = kind_r;
  assign out_byte  = byte_r;

endmodule

FILE: hdl/terminal_escape_key_decoder.sv
// Terminal escape key decoder: turns received bytes and timeouts into key codes.
// Top level; instantiates tekd_in_reg, tekd_decode and tekd_out_reg, uses tekd_pkg.
//
// The block takes one transaction per clock cycle unless the downstream side stalls, and
// holds no stall of its own: an item passes through an input register, one level of
// decode logic and a result register, which holds the key of the byte that completes it.
// Plain bytes give a key at once; ESC and the bytes of a sequence give nothing until
// the sequence ends, and a timeout inside a sequence gives a lone escape key.
// Both registers advance together whenever the result register is empty or being
// read, so throughput follows the downstream tready alone. No clearing pass after reset.
module terminal_escape_key_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       in_tuser,   // [0] op: 1 = timeout, no byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] key_byte
  output logic [3:0] out_tuser   // [3:0] key_kind
);
  import tekd_pkg::*;

  `include "terminal_escape_key_decoder_assert.svh"

  item_t   in_item;
  item_t   item;
  logic    item_vld;
  logic    out_free;
  logic    fire;
  result_t res;

  assign in_item = '{op: in_tuser, rx_byte: in_tdata};
  assign fire    = item_vld && out_free;

  tekd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .fire     (fire),
    .item_vld (item_vld),
    .item     (item)
  );

  tekd_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .res   (res)
  );

  tekd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_byte  (out_tdata)
  );

  `TEKD_ASSERT_SAME(a_byte_only_plain, out_tvalid && (out_tuser != KEY_PLAIN), out_tdata == 8'h00, "key byte set on a non-plain key")
  `TEKD_ASSERT_SAME(a_kind_range, out_tvalid, out_tuser <= KEY_ESCAPE, "key kind out of range")
  `TEKD_ASSERT_NEXT(a_key_loaded, fire && res.vld, out_tvalid, "decoded key was not registered")
  `TEKD_ASSERT_NEXT(a_no_phantom, fire && !res.vld, !out_tvalid, "key appeared without a decode")

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the terminal escape key decoder.
// Drives byte and timeout transactions, predicts the decoded keys and checks them.
// Depends on tekd_pkg and terminal_escape_key_decoder.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tekd_pkg::*;

  localparam int RAND_END       = 1725;
  localparam int TOTAL_END      = 2025;
  localparam int HOLD_AFTER     = 600;
  localparam int HOLD_CYCLES    = 60;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct {
    key_kind_t  kind;
    logic [7:0] kbyte;
  } key_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [3:0] out_tuser;

  item_t  rx_items[$];
  key_t   exp_keys[$];
  int     items_queued = 0;
  int     items_accepted = 0;
  int     err_count = 0;
  int     stuck_cycles = 0;
  int     send_gap = 0;
  int     recv_stall = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;
  bit     long_hold = 1'b0;
  bit     quiet_tail = 1'b0;
  item_t  next_item;
  key_t   want_key;

  // Predictor state of the sequence parser.
  phase_t     parse_ph = PH_IDLE;
  logic [7:0] seq_first = 8'h00;
  logic [3:0] seq_digit = 4'h0;

  terminal_escape_key_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  // Every finished sequence yields one key and sends the parser back to idle.
  task automatic emit_key(input key_kind_t kind, input logic [7:0] kbyte);
    exp_keys.push_back('{kind: kind, kbyte: kbyte});
    parse_ph = PH_IDLE;
  endtask

  task automatic decode_key_step(input logic op, input logic [7:0] c);
    key_kind_t k;
    k = KEY_ESCAPE;
    if (op) begin
      if (parse_ph != PH_IDLE) emit_key(KEY_ESCAPE, 8'h00);
    end else begin
      case (parse_ph)
        PH_IDLE: begin
          if (c == CHAR_ESC) parse_ph = PH_ESC;
          else emit_key(KEY_PLAIN, c);
        end
        PH_ESC: begin
          seq_first = c;
          parse_ph = PH_FIRST;
        end
        PH_FIRST: begin
          if (seq_first == CHAR_CSI && c >= CHAR_ZERO && c <= CHAR_NINE) begin
            seq_digit = c[3:0];
            parse_ph = PH_DIGIT;
          end else begin
            if (seq_first == CHAR_CSI) begin
              case (c)
                CHAR_A: k = KEY_UP;
                CHAR_B: k = KEY_DOWN;
                CHAR_C: k = KEY_RIGHT;
                CHAR_D: k = KEY_LEFT;
                CHAR_H: k = KEY_HOME;
                CHAR_F: k = KEY_END;
                default: k = KEY_ESCAPE;
              endcase
            end else if (seq_first == CHAR_SS3) begin
              if (c == CHAR_H) k = KEY_HOME;
              else if (c == CHAR_F) k = KEY_END;
            end
            emit_key(k, 8'h00);
          end
        end
        default: begin
          if (c == CHAR_TILDE) begin
            case (seq_digit)
              4'd1, 4'd7: k = KEY_HOME;
              4'd4, 4'd8: k = KEY_END;
              4'd3: k = KEY_DEL;
              4'd5: k = KEY_PGUP;
              4'd6: k = KEY_PGDN;
              default: k = KEY_ESCAPE;
            endcase
          end
          emit_key(k, 8'h00);
        end
      endcase
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    rx_items.push_back('{op: 1'b0, rx_byte: b});
    items_queued++;
  endtask

  // The byte lane carries junk during a timeout; the decoder must ignore it.
  task automatic push_timeout();
    rx_items.push_back('{op: 1'b1, rx_byte: 8'($urandom_range(0, 255))});
    items_queued++;
  endtask

  function automatic logic [7:0] pick_final_letter();
    case ($urandom_range(0, 7))
      0: return CHAR_A;
      1: return CHAR_B;
      2: return CHAR_C;
      3: return CHAR_D;
      4: return CHAR_H;
      5: return CHAR_F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_random_sequence();
    int n;
    case ($urandom_range(0, 11))
      0, 1: push_byte(8'($urandom_range(0, 255)));
      2, 3: begin
        push_byte(CHAR_ESC);
        push_byte(CHAR_CSI);
        push_byte(pick_final_letter());
      end
      4, 5: begin
        push_byte(CHAR_ESC);
        push_byte(CHAR_CSI);
        push_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 3) != 0) push_byte(CHAR_TILDE);
        else push_byte(8'($urandom_range(0, 255)));
      end
      6: begin
        push_byte(CHAR_ESC);
        push_byte(CHAR_SS3);
        push_byte(pick_final_letter());
      end
      7: begin
        push_byte(CHAR_ESC);
        push_byte(($urandom_range(0, 3) == 0) ? CHAR_ESC : 8'($urandom_range(0, 255)));
        push_byte(8'($urandom_range(0, 255)));
      end
      8: begin
        // A sequence cut off by a timeout at a random depth.
        push_byte(CHAR_ESC);
        n = $urandom_range(0, 2);
        if (n > 0) push_byte(CHAR_CSI);
        if (n > 1) push_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
        push_timeout();
      end
      9: push_timeout();
      default: begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) push_timeout();
          else push_byte(8'($urandom_range(0, 255)));
        end
      end
    endcase
  endtask

  // Driver: offers the next pending item whenever the previous one is gone, with random gaps before the final stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'h00;
      in_tuser <= 1'b0;
      send_gap = 0;
      parse_ph = PH_IDLE;
      seq_first = 8'h00;
      seq_digit = 4'h0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_key_step(in_tuser, in_tdata);
        items_accepted <= items_accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (!quiet_tail && rx_items.size() != 0 && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 2);
          in_tvalid <= 1'b0;
        end else if (rx_items.size() != 0) begin
          next_item = rx_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= next_item.rx_byte;
          in_tuser <= next_item.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each delivered key against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (exp_keys.size() == 0) begin
          report_mismatch($sformatf("unexpected key kind %0d byte 0x%02h",
                                    out_tuser, out_tdata));
        end else begin
          want_key = exp_keys.pop_front();
          if (out_tuser !== want_key.kind || out_tdata !== want_key.kbyte)
            report_mismatch($sformatf("key kind %0d byte 0x%02h, expected %s byte 0x%02h",
                                      out_tuser, out_tdata, want_key.kind.name(),
                                      want_key.kbyte));
        end
      end
      if (long_hold) begin
        out_tready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        recv_stall = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // One long receiver hold-off while the sender keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      long_hold <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      long_hold <= (hold_left != 0);
    end else if (!hold_done && items_accepted >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      long_hold <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: byte extremes, a timeout while idle, and the corner sequences.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_timeout();
    push_byte(CHAR_ESC); push_byte(CHAR_CSI); push_byte(CHAR_A);
    push_byte(CHAR_ESC); push_byte(CHAR_SS3); push_byte(CHAR_F);
    push_byte(CHAR_ESC); push_byte(CHAR_CSI); push_byte(CHAR_ZERO); push_byte(CHAR_TILDE);
    push_byte(CHAR_ESC); push_timeout();
    push_byte(CHAR_ESC); push_byte(CHAR_ESC); push_byte(CHAR_A);
    push_byte(CHAR_ESC); push_byte(CHAR_CSI); push_byte(CHAR_NINE); push_byte(8'h00);
    push_byte(CHAR_ESC); push_byte(CHAR_CSI); push_timeout();

    // The sender pauses here until every predicted key has been delivered.
    while (rx_items.size() != 0 || in_tvalid) @(negedge clk);
    while (exp_keys.size() != 0) @(negedge clk);

    while (items_queued < RAND_END) add_random_sequence();
    while (rx_items.size() != 0 || in_tvalid) @(negedge clk);

    // Final stretch runs at full rate on both sides.
    quiet_tail = 1'b1;
    while (items_queued < TOTAL_END) add_random_sequence();
    while (rx_items.size() != 0 || in_tvalid) @(negedge clk);
    while (exp_keys.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/tekd_pkg.sv
hdl/tekd_in_reg.sv
hdl/tekd_decode.sv
hdl/tekd_out_reg.sv
hdl/terminal_escape_key_decoder.sv
bench/tb_top.sv
